@@ design/s5hs_pkg.sv @@
package s5hs_pkg;

    typedef enum logic [3:0] {
        PH_GVER  = 4'd0,
        PH_GNUM  = 4'd1,
        PH_METH  = 4'd2,
        PH_RVER  = 4'd3,
        PH_RCMD  = 4'd4,
        PH_RRSV  = 4'd5,
        PH_RATYP = 4'd6,
        PH_DLEN  = 4'd7,
        PH_ADDR  = 4'd8,
        PH_PHI   = 4'd9,
        PH_PLO   = 4'd10,
        PH_CONN  = 4'd11,
        PH_PROXY = 4'd12,
        PH_DEAD  = 4'd13
    } phase_t;

    // work item handed from the front to the back
    typedef enum logic [1:0] {
        OP_ONE    = 2'd0,
        OP_CHOICE = 2'd1,
        OP_REPLY  = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [1:0]  dtype;
        logic [15:0] port;
        logic        close;
    } cmd_t;

    localparam logic [2:0] ACT_CLIENT    = 3'd0;
    localparam logic [2:0] ACT_SERVER    = 3'd1;
    localparam logic [2:0] ACT_CONNECTED = 3'd2;
    localparam logic [2:0] ACT_ERROR     = 3'd3;
    localparam logic [2:0] ACT_CLOSED    = 3'd4;

    localparam logic [2:0] K_TO_CLIENT = 3'd0;
    localparam logic [2:0] K_ADDR      = 3'd1;
    localparam logic [2:0] K_OPEN      = 3'd2;
    localparam logic [2:0] K_CLOSE     = 3'd3;
    localparam logic [2:0] K_TO_SERVER = 3'd4;

    localparam logic [1:0] ERR_HOST    = 2'd1;
    localparam logic [1:0] ERR_REFUSED = 2'd2;

    localparam logic [1:0] DT_IPV4   = 2'd0;
    localparam logic [1:0] DT_DOMAIN = 2'd1;
    localparam logic [1:0] DT_IPV6   = 2'd2;

    localparam logic [7:0] SOCKS_VER    = 8'h05;
    localparam logic [7:0] CMD_CONNECT  = 8'h01;
    localparam logic [7:0] ATYP_IPV4    = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
    localparam logic [7:0] ATYP_IPV6    = 8'h04;
    localparam logic [7:0] REP_OK       = 8'h00;
    localparam logic [7:0] REP_FAIL     = 8'h01;
    localparam logic [7:0] REP_HOST     = 8'h04;
    localparam logic [7:0] REP_REFUSED  = 8'h05;
    localparam logic [7:0] REP_CMD      = 8'h07;
    localparam logic [7:0] REP_ATYP     = 8'h08;

    localparam logic [15:0] PROXY_PORT_RESET = 16'd1080;

    // last result index of each work item
    localparam logic [3:0] IDX_CHOICE_END = 4'd1;
    localparam logic [3:0] IDX_REPLY_END  = 4'd9;
    localparam logic [3:0] IDX_CLOSE      = 4'd10;

endpackage

@@ design/s5hs_front.sv @@
module s5hs_front
    import s5hs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [2:0]  action,
    input  logic [7:0]  in_byte,
    input  logic [1:0]  error_kind,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        cmd_push,
    output cmd_t        cmd
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [1:0]  addr_kind_reg, addr_kind_next;
    logic [7:0]  port_hi_reg, port_hi_next;
    logic [15:0] proxy_port_reg;
    logic [7:0]  rem_dec;

    assign rem_dec = remaining_reg - 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_GVER;
            remaining_reg  <= '0;
            addr_kind_reg  <= '0;
            port_hi_reg    <= '0;
            proxy_port_reg <= PROXY_PORT_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            addr_kind_reg <= addr_kind_next;
            port_hi_reg   <= port_hi_next;
            if (cfg_wr_en)
            begin
                proxy_port_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        addr_kind_next = addr_kind_reg;
        port_hi_next   = port_hi_reg;
        cmd_push       = 1'b0;
        cmd            = '0;
        cmd.op         = OP_ONE;
        if (take)
        begin
            case (action)
                ACT_CLIENT:
                begin
                    unique case (phase_reg)
                        PH_GVER:
                        begin
                            if (in_byte != SOCKS_VER)
                            begin
                                cmd_push   = 1'b1;
                                cmd.op     = OP_REPLY;
                                cmd.data   = REP_FAIL;
                                cmd.close  = 1'b1;
                                phase_next = PH_DEAD;
                            end
                            else
                            begin
                                phase_next = PH_GNUM;
                            end
                        end
                        PH_GNUM:
                        begin
                            remaining_next = in_byte;
                            if (in_byte == 8'd0)
                            begin
                                cmd_push   = 1'b1;
                                cmd.op     = OP_CHOICE;
                                phase_next = PH_RVER;
                            end
                            else
                            begin
                                phase_next = PH_METH;
                            end
                        end
                        PH_METH:
                        begin
                            remaining_next = rem_dec;
                            if (rem_dec == 8'd0)
                            begin
                                cmd_push   = 1'b1;
                                cmd.op     = OP_CHOICE;
                                phase_next = PH_RVER;
                            end
                        end
                        PH_RVER:
                        begin
                            // bit 0: bad version or reserved, bit 1: bad command
                            remaining_next = {7'd0, in_byte != SOCKS_VER};
                            phase_next     = PH_RCMD;
                        end
                        PH_RCMD:
                        begin
                            if (in_byte != CMD_CONNECT)
                            begin
                                remaining_next = remaining_reg | 8'd2;
                            end
                            phase_next = PH_RRSV;
                        end
                        PH_RRSV:
                        begin
                            if (in_byte != 8'd0)
                            begin
                                remaining_next = remaining_reg | 8'd1;
                            end
                            phase_next = PH_RATYP;
                        end
                        PH_RATYP:
                        begin
                            if (remaining_reg[0] || remaining_reg[1] ||
                                !(in_byte == ATYP_IPV4 || in_byte == ATYP_DOMAIN ||
                                  in_byte == ATYP_IPV6))
                            begin
                                cmd_push   = 1'b1;
                                cmd.op     = OP_REPLY;
                                cmd.close  = 1'b1;
                                phase_next = PH_DEAD;
                                if (remaining_reg[0])
                                begin
                                    cmd.data = REP_FAIL;
                                end
                                else if (remaining_reg[1])
                                begin
                                    cmd.data = REP_CMD;
                                end
                                else
                                begin
                                    cmd.data = REP_ATYP;
                                end
                            end
                            else if (in_byte == ATYP_IPV4)
                            begin
                                addr_kind_next = DT_IPV4;
                                remaining_next = 8'd4;
                                phase_next     = PH_ADDR;
                            end
                            else if (in_byte == ATYP_DOMAIN)
                            begin
                                addr_kind_next = DT_DOMAIN;
                                remaining_next = 8'd0;
                                phase_next     = PH_DLEN;
                            end
                            else
                            begin
                                addr_kind_next = DT_IPV6;
                                remaining_next = 8'd16;
                                phase_next     = PH_ADDR;
                            end
                        end
                        PH_DLEN:
                        begin
                            remaining_next = in_byte;
                            phase_next     = (in_byte == 8'd0) ? PH_PHI : PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            cmd_push       = 1'b1;
                            cmd.kind       = K_ADDR;
                            cmd.data       = in_byte;
                            remaining_next = rem_dec;
                            if (rem_dec == 8'd0)
                            begin
                                phase_next = PH_PHI;
                            end
                        end
                        PH_PHI:
                        begin
                            port_hi_next = in_byte;
                            phase_next   = PH_PLO;
                        end
                        PH_PLO:
                        begin
                            cmd_push   = 1'b1;
                            cmd.kind   = K_OPEN;
                            cmd.dtype  = addr_kind_reg;
                            cmd.port   = {port_hi_reg, in_byte};
                            phase_next = PH_CONN;
                        end
                        PH_PROXY:
                        begin
                            cmd_push = 1'b1;
                            cmd.kind = K_TO_SERVER;
                            cmd.data = in_byte;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ACT_SERVER:
                begin
                    if (phase_reg == PH_PROXY)
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = K_TO_CLIENT;
                        cmd.data = in_byte;
                    end
                end
                ACT_CONNECTED:
                begin
                    if (phase_reg == PH_CONN)
                    begin
                        cmd_push   = 1'b1;
                        cmd.op     = OP_REPLY;
                        cmd.data   = REP_OK;
                        cmd.port   = proxy_port_reg;
                        phase_next = PH_PROXY;
                    end
                end
                ACT_ERROR:
                begin
                    if (phase_reg == PH_CONN)
                    begin
                        cmd_push   = 1'b1;
                        cmd.op     = OP_REPLY;
                        cmd.close  = 1'b1;
                        phase_next = PH_DEAD;
                        if (error_kind == ERR_HOST)
                        begin
                            cmd.data = REP_HOST;
                        end
                        else if (error_kind == ERR_REFUSED)
                        begin
                            cmd.data = REP_REFUSED;
                        end
                        else
                        begin
                            cmd.data = REP_FAIL;
                        end
                    end
                    else if (phase_reg == PH_PROXY)
                    begin
                        cmd_push   = 1'b1;
                        cmd.kind   = K_CLOSE;
                        phase_next = PH_DEAD;
                    end
                end
                ACT_CLOSED:
                begin
                    if (phase_reg == PH_CONN || phase_reg == PH_PROXY)
                    begin
                        cmd_push   = 1'b1;
                        cmd.kind   = K_CLOSE;
                        phase_next = PH_DEAD;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ design/s5hs_cmd_fifo.sv @@
module s5hs_cmd_fifo
    import s5hs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic not_empty,
    output logic is_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == FULL_CNT);
    assign rd_cmd    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/s5hs_back.sv @@
module s5hs_back
    import s5hs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_avail,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic        pop,
    output logic        empty,
    output logic [2:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  dest_type,
    output logic [15:0] dest_port,
    output logic        last
);

    logic [3:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [1:0]  dtype_reg, dtype_next;
    logic [15:0] port_reg, port_next;
    logic        last_reg, last_next;
    logic        advance;
    logic [3:0]  end_idx;
    logic [7:0]  reply_byte;

    assign advance = !out_valid_reg || pop;

    always_comb
    begin
        unique case (cmd.op)
            OP_ONE:    end_idx = 4'd0;
            OP_CHOICE: end_idx = IDX_CHOICE_END;
            OP_REPLY:  end_idx = cmd.close ? IDX_CLOSE : IDX_REPLY_END;
            default:   end_idx = 4'd0;
        endcase
    end

    always_comb
    begin
        unique case (idx_reg)
            4'd0:    reply_byte = SOCKS_VER;
            4'd1:    reply_byte = cmd.data;
            4'd3:    reply_byte = 8'h01;
            4'd8:    reply_byte = cmd.port[15:8];
            4'd9:    reply_byte = cmd.port[7:0];
            default: reply_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        dtype_next     = dtype_reg;
        port_next      = port_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        if (advance)
        begin
            out_valid_next = cmd_avail;
            if (cmd_avail)
            begin
                last_next  = (idx_reg == end_idx);
                dtype_next = '0;
                port_next  = '0;
                unique case (cmd.op)
                    OP_ONE:
                    begin
                        kind_next  = cmd.kind;
                        byte_next  = cmd.data;
                        dtype_next = cmd.dtype;
                        port_next  = cmd.port;
                    end
                    OP_CHOICE:
                    begin
                        kind_next = K_TO_CLIENT;
                        byte_next = (idx_reg == 4'd0) ? SOCKS_VER : 8'h00;
                    end
                    default:
                    begin
                        if (idx_reg == IDX_CLOSE)
                        begin
                            kind_next = K_CLOSE;
                            byte_next = 8'h00;
                        end
                        else
                        begin
                            kind_next = K_TO_CLIENT;
                            byte_next = reply_byte;
                        end
                    end
                endcase
                // drop the work item once its final result is out
                if (idx_reg == end_idx)
                begin
                    cmd_pop  = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        dtype_reg <= dtype_next;
        port_reg  <= port_next;
        last_reg  <= last_next;
    end

    assign empty     = !out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign dest_type = dtype_reg;
    assign dest_port = port_reg;
    assign last      = last_reg;

endmodule

@@ design/socks5_server_handshake_top.sv @@
// A taken input is written to the work queue; the result sequencer then registers each
// result onto the output ports. One input per cycle while full is low; the sequencer emits
// one result per cycle while pop keeps up, so a reply holds it while the queue buffers the front.
// Reset (rst_n low, asynchronous): greeting phase, queues empty, proxy_port = 1080.
module socks5_server_handshake_top
    import s5hs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  action,
    input  logic [7:0]  in_byte,
    input  logic [1:0]  error_kind,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  dest_type,
    output logic [15:0] dest_port,
    output logic        last
);

    logic take;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_head;
    logic cmd_avail;
    logic cmd_pop;
    logic q_full;

    assign full = q_full;
    assign take = push && !q_full;

    s5hs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .action      (action),
        .in_byte     (in_byte),
        .error_kind  (error_kind),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    s5hs_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_push),
        .wr_cmd    (cmd_in),
        .rd_en     (cmd_pop),
        .rd_cmd    (cmd_head),
        .not_empty (cmd_avail),
        .is_full   (q_full)
    );

    s5hs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .dest_type (dest_type),
        .dest_port (dest_port),
        .last      (last)
    );

endmodule

@@ bench/socks5_handshake_checker.sv @@
`timescale 1ns / 1ps

module socks5_handshake_checker
    import s5hs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  action,
    input  logic [7:0]  in_byte,
    input  logic [1:0]  error_kind,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  out_kind,
    input  logic [7:0]  out_byte,
    input  logic [1:0]  dest_type,
    input  logic [15:0] dest_port,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [1:0]  dtype;
        logic [15:0] port;
        logic        last;
    } egress_t;

    localparam int         MAX_PER_REQUEST = 11;
    localparam logic [7:0] METHOD_NO_AUTH  = 8'h00;
    localparam logic [7:0] RSV_BYTE        = 8'h00;
    localparam logic [7:0] HDR_BAD_FIELD   = 8'h01;
    localparam logic [7:0] HDR_BAD_CMD     = 8'h02;

    phase_t      phase;
    logic [7:0]  remaining;
    logic [1:0]  addr_kind;
    logic [15:0] port_acc;
    logic [15:0] proxy_port;
    egress_t     step_q[$];
    egress_t     due_q[$];

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic add_result(input logic [2:0] kind, input logic [7:0] data,
                              input logic [1:0] dtype, input logic [15:0] port);
        if (step_q.size() < MAX_PER_REQUEST)
            step_q.push_back('{kind, data, dtype, port, 1'b0});
    endtask

    task automatic add_reply(input logic [7:0] rep, input logic [15:0] port);
        add_result(K_TO_CLIENT, SOCKS_VER, '0, '0);
        add_result(K_TO_CLIENT, rep, '0, '0);
        add_result(K_TO_CLIENT, RSV_BYTE, '0, '0);
        add_result(K_TO_CLIENT, ATYP_IPV4, '0, '0);
        repeat (4) add_result(K_TO_CLIENT, 8'h00, '0, '0);
        add_result(K_TO_CLIENT, port[15:8], '0, '0);
        add_result(K_TO_CLIENT, port[7:0], '0, '0);
    endtask

    task automatic shut_down(input logic [7:0] rep);
        add_reply(rep, '0);
        add_result(K_CLOSE, '0, '0, '0);
        phase = PH_DEAD;
    endtask

    task automatic grant_no_auth();
        add_result(K_TO_CLIENT, SOCKS_VER, '0, '0);
        add_result(K_TO_CLIENT, METHOD_NO_AUTH, '0, '0);
        phase = PH_RVER;
    endtask

    task automatic take_client(input logic [7:0] b);
        case (phase)
            PH_GVER:
                if (b != SOCKS_VER)
                    shut_down(REP_FAIL);
                else
                    phase = PH_GNUM;
            PH_GNUM:
            begin
                remaining = b;
                if (b == 8'd0)
                    grant_no_auth();
                else
                    phase = PH_METH;
            end
            PH_METH:
            begin
                remaining = remaining - 8'd1;
                if (remaining == 8'd0)
                    grant_no_auth();
            end
            // collect header faults; they are judged once the address type arrives
            PH_RVER:
            begin
                remaining = (b != SOCKS_VER) ? HDR_BAD_FIELD : 8'd0;
                phase = PH_RCMD;
            end
            PH_RCMD:
            begin
                if (b != CMD_CONNECT)
                    remaining = remaining | HDR_BAD_CMD;
                phase = PH_RRSV;
            end
            PH_RRSV:
            begin
                if (b != RSV_BYTE)
                    remaining = remaining | HDR_BAD_FIELD;
                phase = PH_RATYP;
            end
            PH_RATYP:
            begin
                if ((remaining & HDR_BAD_FIELD) != 8'd0)
                    shut_down(REP_FAIL);
                else if ((remaining & HDR_BAD_CMD) != 8'd0)
                    shut_down(REP_CMD);
                else if (b == ATYP_IPV4)
                begin
                    addr_kind = DT_IPV4;
                    remaining = 8'd4;
                    phase = PH_ADDR;
                end
                else if (b == ATYP_DOMAIN)
                begin
                    addr_kind = DT_DOMAIN;
                    remaining = 8'd0;
                    phase = PH_DLEN;
                end
                else if (b == ATYP_IPV6)
                begin
                    addr_kind = DT_IPV6;
                    remaining = 8'd16;
                    phase = PH_ADDR;
                end
                else
                    shut_down(REP_ATYP);
            end
            PH_DLEN:
            begin
                remaining = b;
                phase = (b == 8'd0) ? PH_PHI : PH_ADDR;
            end
            PH_ADDR:
            begin
                add_result(K_ADDR, b, '0, '0);
                remaining = remaining - 8'd1;
                if (remaining == 8'd0)
                    phase = PH_PHI;
            end
            PH_PHI:
            begin
                port_acc = {b, 8'h00};
                phase = PH_PLO;
            end
            PH_PLO:
            begin
                port_acc = port_acc | {8'h00, b};
                add_result(K_OPEN, '0, addr_kind, port_acc);
                phase = PH_CONN;
            end
            PH_PROXY:
                add_result(K_TO_SERVER, b, '0, '0);
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_request(input logic [2:0] act, input logic [7:0] b,
                                   input logic [1:0] ek);
        step_q.delete();
        case (act)
            ACT_CLIENT:
                take_client(b);
            ACT_SERVER:
                if (phase == PH_PROXY)
                    add_result(K_TO_CLIENT, b, '0, '0);
            ACT_CONNECTED:
                if (phase == PH_CONN)
                begin
                    add_reply(REP_OK, proxy_port);
                    phase = PH_PROXY;
                end
            ACT_ERROR:
                if (phase == PH_CONN)
                    shut_down(ek == ERR_HOST ? REP_HOST :
                              (ek == ERR_REFUSED ? REP_REFUSED : REP_FAIL));
                else if (phase == PH_PROXY)
                begin
                    add_result(K_CLOSE, '0, '0, '0);
                    phase = PH_DEAD;
                end
            ACT_CLOSED:
                if (phase == PH_CONN || phase == PH_PROXY)
                begin
                    add_result(K_CLOSE, '0, '0, '0);
                    phase = PH_DEAD;
                end
            default:
            begin
            end
        endcase
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            due_q.push_back(step_q[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        egress_t want;
        if (!rst_n)
        begin
            phase = PH_GVER;
            remaining = '0;
            addr_kind = '0;
            port_acc = '0;
            proxy_port = PROXY_PORT_RESET;
            due_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
                proxy_port = cfg_wr_data;
            if (pop && !empty)
            begin
                if (due_q.size() == 0)
                    report($sformatf("result kind %0d byte %02h with nothing expected",
                                     out_kind, out_byte));
                else
                begin
                    want = due_q.pop_front();
                    if (out_kind !== want.kind)
                        report($sformatf("out_kind %0d, want %0d", out_kind, want.kind));
                    if (out_byte !== want.data)
                        report($sformatf("out_byte %02h, want %02h", out_byte, want.data));
                    if (dest_type !== want.dtype)
                        report($sformatf("dest_type %0d, want %0d", dest_type, want.dtype));
                    if (dest_port !== want.port)
                        report($sformatf("dest_port %0d, want %0d", dest_port, want.port));
                    if (last !== want.last)
                        report($sformatf("last %0b, want %0b", last, want.last));
                end
            end
            if (push && !full)
                predict_request(action, in_byte, error_kind);
            pending = due_q.size();
        end
    end

endmodule

@@ bench/socks5_server_handshake_top_tb.sv @@
`timescale 1ns / 1ps

module socks5_server_handshake_top_tb;
    import s5hs_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int         RANDOM_ITEMS = 220;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  action = '0;
    logic [7:0]  in_byte = '0;
    logic [1:0]  error_kind = '0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  dest_type;
    logic [15:0] dest_port;
    logic        last;

    int fail_count;
    int pending;
    int pop_hold = 0;
    bit steady = 1'b0;

    socks5_server_handshake_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .in_byte     (in_byte),
        .error_kind  (error_kind),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .empty       (empty),
        .pop         (pop),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .dest_type   (dest_type),
        .dest_port   (dest_port),
        .last        (last)
    );

    socks5_handshake_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .in_byte     (in_byte),
        .error_kind  (error_kind),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .empty       (empty),
        .pop         (pop),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .dest_type   (dest_type),
        .dest_port   (dest_port),
        .last        (last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // no gap half the time (always when steady), some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (steady || r < 8)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                pop_hold <= pick_gap();
        end
    end

    task automatic send_request(input logic [2:0] act, input logic [7:0] b,
                                input logic [1:0] ek);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        action <= act;
        in_byte <= b;
        error_kind <= ek;
        do @(posedge clk); while (full);
    endtask

    // drop push and hold until every expected result has been taken
    task automatic settle();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_proxy_port(input logic [15:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    initial
    begin : stimulus
        int          n_meth;
        int          n_addr;
        int          r;
        logic [7:0]  atyp;
        logic [15:0] dport;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_proxy_port(16'h0000);

        // outbound events before any open request are ignored
        send_request(ACT_CONNECTED, 8'h00, 2'd0);
        send_request(ACT_ERROR, 8'hFF, ERR_REFUSED);
        send_request(ACT_CLOSED, 8'h00, ERR_HOST);

        n_meth = $urandom_range(0, 2);
        send_request(ACT_CLIENT, SOCKS_VER, 2'd0);
        send_request(ACT_CLIENT, 8'(n_meth), 2'd0);
        repeat (n_meth) send_request(ACT_CLIENT, 8'($urandom), 2'd0);
        write_proxy_port(16'hFFFF);

        r = $urandom_range(0, 3);
        case (r)
            0:
            begin
                atyp = ATYP_IPV4;
                n_addr = 4;
            end
            1:
            begin
                atyp = ATYP_DOMAIN;
                n_addr = $urandom_range(1, 6);
            end
            2:
            begin
                atyp = ATYP_DOMAIN;
                n_addr = 0;
            end
            default:
            begin
                atyp = ATYP_IPV6;
                n_addr = 16;
            end
        endcase
        send_request(ACT_CLIENT, SOCKS_VER, 2'd0);
        send_request(ACT_CLIENT, CMD_CONNECT, 2'd0);
        send_request(ACT_CLIENT, 8'h00, 2'd0);
        send_request(ACT_CLIENT, atyp, 2'd0);
        if (atyp == ATYP_DOMAIN)
            send_request(ACT_CLIENT, 8'(n_addr), 2'd0);
        for (int i = 0; i < n_addr; i++)
            send_request(ACT_CLIENT, (i == 0) ? 8'h00 : ((i == 1) ? 8'hFF : 8'($urandom)),
                         2'd0);
        dport = pick_port();
        send_request(ACT_CLIENT, dport[15:8], 2'd0);
        send_request(ACT_CLIENT, dport[7:0], 2'd0);

        // while connecting: client bytes dropped, server bytes and spare actions ignored
        send_request(ACT_CLIENT, 8'hA5, 2'd0);
        send_request(ACT_SERVER, 8'h5A, 2'd0);
        send_request(ACT_SPARE_HI, 8'hFF, ERR_REFUSED);
        write_proxy_port(pick_port());
        send_request(ACT_CONNECTED, 8'h00, 2'd0);
        send_request(ACT_CONNECTED, 8'h00, 2'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_ITEMS / 2)
                write_proxy_port(16'($urandom));
            r = $urandom_range(0, 15);
            if (r < 7)
                send_request(ACT_CLIENT, 8'($urandom), 2'($urandom_range(0, 2)));
            else if (r < 14)
                send_request(ACT_SERVER, 8'($urandom), 2'($urandom_range(0, 2)));
            else if (r == 14)
                send_request(ACT_CONNECTED, 8'($urandom), 2'($urandom_range(0, 2)));
            else
                send_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 8'($urandom),
                             2'($urandom_range(0, 2)));
        end
        steady = 1'b0;

        if ($urandom_range(0, 1) == 0)
            send_request(ACT_ERROR, 8'($urandom), 2'($urandom_range(0, 2)));
        else
            send_request(ACT_CLOSED, 8'($urandom), 2'd0);
        // inert after the close
        send_request(ACT_CLIENT, 8'($urandom), 2'd0);
        send_request(ACT_SERVER, 8'($urandom), 2'd0);
        send_request(ACT_CONNECTED, 8'h00, 2'd0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("socks5_server_handshake_top_tb passed");
        else
            $display("socks5_server_handshake_top_tb failed");
        $finish;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("socks5_server_handshake_top_tb failed");
        $finish;
    end

endmodule
